### design/swmax_pkg.sv
// ----------------------------------------------------------------------------
// swmax_pkg
// Shared widths, register indexes, grid mode codes and the grid mode function
// of the sliding window maximum autoscale block.
// ----------------------------------------------------------------------------
package swmax_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int NUM_W       = SAMPLE_W + 1;   // sample plus scale minus one
  localparam int COUNT_W     = 8;
  localparam int MODE_W      = 2;
  localparam int WLEN_W      = 11;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_LOWER    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_UPPER    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ENABLE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VISIBLE_LIMIT = 3'd4;

  localparam logic [MODE_W-1:0] GRID_HIDDEN = 2'd0;
  localparam logic [MODE_W-1:0] GRID_ALL    = 2'd1;
  localparam logic [MODE_W-1:0] GRID_TOP    = 2'd2;

  function automatic logic [MODE_W-1:0] grid_mode_f(
    input logic               en,
    input logic [COUNT_W-1:0] vis,
    input logic [COUNT_W-1:0] cnt
  );
    logic [MODE_W-1:0] m;
    if (!en) begin
      m = GRID_HIDDEN;
    end else if (cnt > vis) begin
      m = GRID_TOP;
    end else begin
      m = GRID_ALL;
    end
    return m;
  endfunction

endpackage

### design/swmax_ring.sv
// ----------------------------------------------------------------------------
// swmax_ring
// Sample ring storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module swmax_ring
  import swmax_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [SAMPLE_W-1:0]      wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [SAMPLE_W-1:0]      rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/swmax_cdiv.sv
// ----------------------------------------------------------------------------
// swmax_cdiv
// Division by the constant sample scale through one reciprocal multiplication;
// the quotient and its done flag are registered, ready in the cycle after start.
// ----------------------------------------------------------------------------
module swmax_cdiv
  import swmax_pkg::*;
#(
  parameter int SAMPLE_SCALE = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  // reciprocal rounded up with NUM_W + log2(scale) fraction bits is exact
  // for every NUM_W-bit numerator; the factor itself fits in NUM_W + 2 bits
  localparam int SHIFT = NUM_W + $clog2(SAMPLE_SCALE);
  localparam int PW    = SHIFT + NUM_W;
  localparam logic [PW-1:0] RECIP =
    PW'(((64'd1 << SHIFT) + 64'(SAMPLE_SCALE) - 64'd1) / 64'(SAMPLE_SCALE));

  logic [PW-1:0]    prod;
  logic [NUM_W-1:0] quot_r, quot_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    prod     = PW'(num) * RECIP;
    quot_nxt = start ? prod[SHIFT +: NUM_W] : quot_r;
    done_nxt = start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### design/sliding_window_max_autoscale_core.sv
// ----------------------------------------------------------------------------
// sliding_window_max_autoscale_core
// Sliding window maximum over a sample ring with grid line autoscale.
// ----------------------------------------------------------------------------
// Each input transaction on in_* carries one sample. The sample replaces the
// oldest entry of a ring of window_length entries, and one result transaction
// on out_* reports the window maximum, the clamped grid line count, the grid
// mode, a rescale flag and the sample that was overwritten.
// Configuration goes through cfg_we / cfg_addr / cfg_wdata, one register per
// write; the user must do so only while no transaction is in flight, which
// the block itself does not enforce. One item at a time: in_tready is high
// only while the sequencer is idle. Each item passes the idle, old-sample,
// check and done states; a changed maximum adds the scale division by
// reciprocal multiplication; an overwritten maximum adds a ring scan,
// as the single read port walks the whole window one entry a cycle.
// The result sits in an output register; a stalled receiver holds it there,
// and the next item is still taken, but its result waits until the register
// drains. Reset restores the register defaults and empties the ring: a fill
// mark tracks the written prefix, so no clearing pass is needed and the
// block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module sliding_window_max_autoscale_core
  import swmax_pkg::*;
#(
  parameter int DEPTH        = 1024,
  parameter int SAMPLE_SCALE = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] window_max, [23:16] grid_count, [25:24] grid_mode, [26] rescaled,
  // [42:27] evicted_sample, [47:43] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > WLEN_W) ? LW : WLEN_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_OLD, ST_SCAN, ST_CHECK, ST_DIV, ST_DONE
  } state_t;

  state_t               state_r,   state_nxt;
  logic [SAMPLE_W-1:0]  sample_r,  sample_nxt;
  logic [AW-1:0]        addr_r,    addr_nxt;
  logic [SAMPLE_W-1:0]  old_r,     old_nxt;
  logic [SAMPLE_W-1:0]  nmax_r,    nmax_nxt;
  logic [SAMPLE_W-1:0]  max_r,     max_nxt;
  logic [COUNT_W-1:0]   count_r,   count_nxt;
  logic [MODE_W-1:0]    mode_r,    mode_nxt;
  logic                 resc_r,    resc_nxt;
  logic [AW-1:0]        wp_r,      wp_nxt;
  logic [LW-1:0]        fill_r,    fill_nxt;
  logic [LW-1:0]        idx_r,     idx_nxt;
  logic                 pv_r,      pv_nxt;
  logic [LW-1:0]        pidx_r,    pidx_nxt;
  logic [WLEN_W-1:0]    wlen_r,    wlen_nxt;
  logic [COUNT_W-1:0]   glo_r,     glo_nxt;
  logic [COUNT_W-1:0]   ghi_r,     ghi_nxt;
  logic                 gen_r,     gen_nxt;
  logic [COUNT_W-1:0]   vis_r,     vis_nxt;
  logic                 ovalid_r,  ovalid_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0]  ram_wdata, ram_rdata;

  logic                 div_start, div_done;
  logic [NUM_W-1:0]     div_num, div_quot;

  logic [CW-1:0]        wlen_ext;
  logic [LW-1:0]        len;
  logic [AW-1:0]        wp_eff;
  logic [LW-1:0]        a_inc;
  logic [SAMPLE_W-1:0]  old_val;
  logic [COUNT_W-1:0]   lo_eff, hi_eff;
  logic [NUM_W-1:0]     cnt_wide;
  logic [COUNT_W-1:0]   cnt_new;

  swmax_ring #(.DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swmax_cdiv #(.SAMPLE_SCALE(SAMPLE_SCALE)) u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot)
  );

  // effective window length, write pointer, next address and old sample value
  always_comb begin
    wlen_ext = CW'(wlen_r);
    if (wlen_r == '0) begin
      len = LW'(1);
    end else if (wlen_ext > CW'(DEPTH)) begin
      len = LW'(DEPTH);
    end else begin
      len = LW'(wlen_ext);
    end
    wp_eff  = (LW'(wp_r) < len) ? wp_r : '0;
    a_inc   = LW'(addr_r) + LW'(1);
    // entries past the fill mark were never written and read as zero
    old_val = (LW'(addr_r) < fill_r) ? ram_rdata : '0;
  end

  // count clamp
  always_comb begin
    lo_eff   = (glo_r == '0) ? COUNT_W'(1) : glo_r;
    hi_eff   = (ghi_r != '0 && ghi_r < lo_eff) ? lo_eff : ghi_r;
    cnt_wide = div_quot;
    if (cnt_wide < NUM_W'(lo_eff)) begin
      cnt_wide = NUM_W'(lo_eff);
    end
    if (hi_eff != '0 && cnt_wide > NUM_W'(hi_eff)) begin
      cnt_wide = NUM_W'(hi_eff);
    end
    if (cnt_wide > NUM_W'(8'hFF)) begin
      cnt_wide = NUM_W'(8'hFF);
    end
    cnt_new = cnt_wide[COUNT_W-1:0];
  end

  assign div_num = NUM_W'(nmax_r) + NUM_W'(SAMPLE_SCALE - 1);

  always_comb begin
    state_nxt  = state_r;
    sample_nxt = sample_r;
    addr_nxt   = addr_r;
    old_nxt    = old_r;
    nmax_nxt   = nmax_r;
    max_nxt    = max_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    resc_nxt   = resc_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    pv_nxt     = pv_r;
    pidx_nxt   = pidx_r;
    wlen_nxt   = wlen_r;
    glo_nxt    = glo_r;
    ghi_nxt    = ghi_r;
    gen_nxt    = gen_r;
    vis_nxt    = vis_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ram_we     = 1'b0;
    ram_waddr  = addr_r;
    ram_wdata  = sample_r;
    ram_re     = 1'b0;
    ram_raddr  = wp_eff;
    div_start  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[SAMPLE_W-1:0];
          addr_nxt   = wp_eff;
          ram_re     = 1'b1;
          state_nxt  = ST_OLD;
        end
      end
      ST_OLD: begin
        ram_we   = 1'b1;
        old_nxt  = old_val;
        resc_nxt = 1'b0;
        wp_nxt   = (a_inc >= len) ? '0 : AW'(a_inc);
        if (a_inc > fill_r) begin
          fill_nxt = a_inc;
        end
        if (sample_r > max_r) begin
          nmax_nxt  = sample_r;
          state_nxt = ST_CHECK;
        end else if (old_val == max_r) begin
          // the maximum left the window: walk the ring
          nmax_nxt  = '0;
          idx_nxt   = '0;
          pv_nxt    = 1'b0;
          state_nxt = ST_SCAN;
        end else begin
          nmax_nxt  = max_r;
          state_nxt = ST_CHECK;
        end
      end
      ST_SCAN: begin
        if (idx_r < len) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + LW'(1);
          pv_nxt    = 1'b1;
          pidx_nxt  = idx_r;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && pidx_r < fill_r && ram_rdata > nmax_r) begin
          nmax_nxt = ram_rdata;
        end
        if (idx_r >= len && !pv_r) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (nmax_r != max_r) begin
          max_nxt   = nmax_r;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (cnt_new != count_r) begin
            count_nxt = cnt_new;
            resc_nxt  = 1'b1;
            if (mode_r != GRID_HIDDEN) begin
              mode_nxt = grid_mode_f(gen_r, vis_r, cnt_new);
            end
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {5'd0, old_r, resc_r, mode_r, count_r, max_r};
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW_LENGTH: wlen_nxt = cfg_wdata;
        REG_GRID_LOWER:    glo_nxt  = cfg_wdata[COUNT_W-1:0];
        REG_GRID_UPPER:    ghi_nxt  = cfg_wdata[COUNT_W-1:0];
        REG_GRID_ENABLE: begin
          gen_nxt  = cfg_wdata[0];
          mode_nxt = grid_mode_f(cfg_wdata[0], vis_r, count_r);
        end
        REG_VISIBLE_LIMIT: begin
          vis_nxt  = cfg_wdata[COUNT_W-1:0];
          mode_nxt = grid_mode_f(gen_r, cfg_wdata[COUNT_W-1:0], count_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      max_r    <= '0;
      count_r  <= COUNT_W'(1);
      mode_r   <= GRID_ALL;
      wp_r     <= '0;
      fill_r   <= '0;
      pv_r     <= 1'b0;
      idx_r    <= '0;
      wlen_r   <= WLEN_W'(1024);
      glo_r    <= COUNT_W'(1);
      ghi_r    <= '0;
      gen_r    <= 1'b1;
      vis_r    <= COUNT_W'(10);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      max_r    <= max_nxt;
      count_r  <= count_nxt;
      mode_r   <= mode_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      pv_r     <= pv_nxt;
      idx_r    <= idx_nxt;
      wlen_r   <= wlen_nxt;
      glo_r    <= glo_nxt;
      ghi_r    <= ghi_nxt;
      gen_r    <= gen_nxt;
      vis_r    <= vis_nxt;
      ovalid_r <= ovalid_nxt;
    end
    sample_r <= sample_nxt;
    addr_r   <= addr_nxt;
    old_r    <= old_nxt;
    nmax_r   <= nmax_nxt;
    resc_r   <= resc_nxt;
    pidx_r   <= pidx_nxt;
    odata_r  <= odata_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule
